[src/gfc_pkg.sv]
// ============================================================================
// gfc_pkg
// Shared types and constants for the gamepad frame conditioner.
// ============================================================================
package gfc_pkg;

  // Default number of samples buffered per frame.
  localparam int SNAP_DEPTH_DEF = 4;

  // Operation codes carried by an input transaction.
  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Stick thresholds.
  localparam int MENU_THRESH = 35;
  localparam int DEAD_BAND   = 8;
  localparam int DEAD_LIMIT  = 70;

  // Configuration register reset values.
  localparam logic [15:0] EDGE_MASK_RST    = 16'hFFFF;
  localparam logic [6:0]  REPEAT_DELAY_RST = 7'd5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NO_CONTROLLER = 2'd0,
    CFG_EDGE_MASK     = 2'd1,
    CFG_REPEAT_DELAY  = 2'd2,
    CFG_IGNORE_STICK  = 2'd3
  } cfg_index_t;

endpackage

[src/gamepad_frame_conditioner_core.sv]
// Sequence: arm transactions and unarmed poll ticks leave the input open; an armed
// poll tick is followed by S_DIV, where one bit-serial divider does x then y, a
// bit a cycle, and S_FINISH, which loads the output register and raises out_valid.
// Input: after an armed tick the input stays closed through S_DIV and S_FINISH,
// longer while the previous result still waits in the output register.
// Reset: synchronous, active low; restores register defaults, clears frame state.
// ============================================================================
// gamepad_frame_conditioner_core
// Per-controller input conditioner: buffers poll samples, finds masked
// button edges, and on an armed tick emits button ORs, stick averages,
// menu auto-repeat steps and deadzoned sticks.
// ============================================================================
module gamepad_frame_conditioner_core
  import gfc_pkg::*;
#(
  parameter int SNAP_DEPTH = SNAP_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic                in_has_new_data,
  input  logic [15:0]         in_pad_buttons,
  input  logic signed [7:0]   in_pad_stick_x,
  input  logic signed [7:0]   in_pad_stick_y,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_frame_buttons,
  output logic [15:0]         out_frame_presses,
  output logic [15:0]         out_frame_releases,
  output logic signed [7:0]   out_avg_x,
  output logic signed [7:0]   out_avg_y,
  output logic signed [1:0]   out_menu_x_sign,
  output logic signed [1:0]   out_menu_y_sign,
  output logic signed [7:0]   out_dead_x,
  output logic signed [7:0]   out_dead_y
);

  localparam int CNT_W  = $clog2(SNAP_DEPTH + 1);
  localparam int SUM_W  = 8 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [1:0] sign;
    logic signed [7:0] last;
    logic [7:0]        hold;
  } menu_t;

  // Menu auto-repeat update for one axis.
  function automatic menu_t menu_step(input logic signed [7:0] v,
                                      input logic signed [7:0] last,
                                      input logic [7:0]        hold,
                                      input logic [6:0]        delay);
    menu_t      m;
    logic       lo;
    logic       hi;
    logic [7:0] h;
    lo     = v < -8'(MENU_THRESH);
    hi     = v > 8'(MENU_THRESH);
    h      = hold;
    m.sign = 2'sb00;
    if (lo && last >= -8'(MENU_THRESH)) begin
      m.sign = -2'sd1;
      h      = 8'd0;
    end
    if (hi && last <= 8'(MENU_THRESH)) begin
      m.sign = 2'sd1;
      h      = 8'd0;
    end
    m.last = v;
    if (lo || hi) begin
      h = h + 8'd1;
    end else begin
      h = 8'd0;
    end
    // The hold timer is compared as a signed byte.
    if ($signed({2'b00, delay}) < $signed({h[7], h})) begin
      m.last = 8'sd0;
      h      = 8'd0;
    end
    m.hold = h;
    return m;
  endfunction

  // Deadzone shift and clamp for one axis.
  function automatic logic signed [7:0] dead_zone(input logic signed [7:0] s,
                                                  input logic              ign);
    logic signed [8:0] t;
    logic signed [7:0] r;
    t = 9'(s);
    if (ign) begin
      r = 8'sd0;
    end else if (s < 8'(DEAD_BAND) && s > -8'(DEAD_BAND)) begin
      r = 8'sd0;
    end else if (s > 8'sd0) begin
      t = t - 9'(DEAD_BAND);
      r = (t > 9'(DEAD_LIMIT)) ? 8'(DEAD_LIMIT) : t[7:0];
    end else begin
      t = t + 9'(DEAD_BAND);
      r = (t < -9'(DEAD_LIMIT)) ? -8'(DEAD_LIMIT) : t[7:0];
    end
    return r;
  endfunction

  // Control and frame state.
  state_t                    state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      no_ctrl_r, no_ctrl_nxt;
  logic [15:0]               edge_mask_r, edge_mask_nxt;
  logic [6:0]                rep_delay_r, rep_delay_nxt;
  logic                      ign_stick_r, ign_stick_nxt;
  logic [15:0]               prev_btn_r, prev_btn_nxt;
  logic signed [7:0]         prev_x_r, prev_x_nxt;
  logic signed [7:0]         prev_y_r, prev_y_nxt;
  logic [15:0]               acc_btn_r, acc_btn_nxt;
  logic [15:0]               acc_pr_r, acc_pr_nxt;
  logic [15:0]               acc_rl_r, acc_rl_nxt;
  logic signed [SUM_W-1:0]   sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0]   sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      armed_r, armed_nxt;
  logic signed [7:0]         last_mx_r, last_mx_nxt;
  logic signed [7:0]         last_my_r, last_my_nxt;
  logic [7:0]                hold_x_r, hold_x_nxt;
  logic [7:0]                hold_y_r, hold_y_nxt;

  // Divider datapath and result payload.
  logic [SUM_W-1:0]          dq_r, dq_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      axis_r, axis_nxt;
  logic signed [7:0]         avg_x_r, avg_x_nxt;
  logic signed [7:0]         avg_y_r, avg_y_nxt;
  logic [15:0]               o_btn_r, o_btn_nxt;
  logic [15:0]               o_pr_r, o_pr_nxt;
  logic [15:0]               o_rl_r, o_rl_nxt;
  logic signed [7:0]         o_ax_r, o_ax_nxt;
  logic signed [7:0]         o_ay_r, o_ay_nxt;
  logic signed [1:0]         o_sx_r, o_sx_nxt;
  logic signed [1:0]         o_sy_r, o_sy_nxt;
  logic signed [7:0]         o_dx_r, o_dx_nxt;
  logic signed [7:0]         o_dy_r, o_dy_nxt;

  // Helper signals.
  logic                      in_acc;
  logic [15:0]               cap_btn;
  logic signed [7:0]         cap_x;
  logic signed [7:0]         cap_y;
  logic [15:0]               cap_diff;
  logic [CNT_W:0]            trial;
  logic                      trial_ge;
  logic [SUM_W-1:0]          quo;
  logic                      quo_neg;
  logic signed [7:0]         quo_s;
  menu_t                     mx;
  menu_t                     my;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Sample selection and edge detection for a capturing tick.
  always_comb begin
    cap_btn = in_has_new_data ? in_pad_buttons : prev_btn_r;
    cap_x   = in_has_new_data ? in_pad_stick_x : prev_x_r;
    cap_y   = in_has_new_data ? in_pad_stick_y : prev_y_r;
    if (no_ctrl_r) begin
      cap_btn = 16'd0;
    end
    cap_diff = cap_btn ^ prev_btn_r;
  end

  // One restoring divide step: magnitude of the sum over the sample count.
  always_comb begin
    trial    = {rem_r, dq_r[SUM_W-1]};
    trial_ge = trial >= {1'b0, count_r};
    quo      = {dq_r[SUM_W-2:0], trial_ge};
    quo_neg  = axis_r ? sum_y_r[SUM_W-1] : sum_x_r[SUM_W-1];
    quo_s    = quo_neg ? -$signed(quo[7:0]) : $signed(quo[7:0]);
  end

  // Menu repeat logic on the finished averages.
  assign mx = menu_step(avg_x_r, last_mx_r, hold_x_r, rep_delay_r);
  assign my = menu_step(avg_y_r, last_my_r, hold_y_r, rep_delay_r);

  // Next-state logic for the sequencer and all registers.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    no_ctrl_nxt   = no_ctrl_r;
    edge_mask_nxt = edge_mask_r;
    rep_delay_nxt = rep_delay_r;
    ign_stick_nxt = ign_stick_r;
    prev_btn_nxt  = prev_btn_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    acc_btn_nxt   = acc_btn_r;
    acc_pr_nxt    = acc_pr_r;
    acc_rl_nxt    = acc_rl_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    count_nxt     = count_r;
    armed_nxt     = armed_r;
    last_mx_nxt   = last_mx_r;
    last_my_nxt   = last_my_r;
    hold_x_nxt    = hold_x_r;
    hold_y_nxt    = hold_y_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    axis_nxt      = axis_r;
    avg_x_nxt     = avg_x_r;
    avg_y_nxt     = avg_y_r;
    o_btn_nxt     = o_btn_r;
    o_pr_nxt      = o_pr_r;
    o_rl_nxt      = o_rl_r;
    o_ax_nxt      = o_ax_r;
    o_ay_nxt      = o_ay_r;
    o_sx_nxt      = o_sx_r;
    o_sy_nxt      = o_sy_r;
    o_dx_nxt      = o_dx_r;
    o_dy_nxt      = o_dy_r;

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_NO_CONTROLLER: no_ctrl_nxt   = cfg_wdata[0];
        CFG_EDGE_MASK:     edge_mask_nxt = cfg_wdata;
        CFG_REPEAT_DELAY:  rep_delay_nxt = cfg_wdata[6:0];
        CFG_IGNORE_STICK:  ign_stick_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    // The result register empties when its transaction completes.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_ARM) begin
            armed_nxt = 1'b1;
          end else begin
            // Capture while the frame buffer has room.
            if (count_r < CNT_W'(SNAP_DEPTH)) begin
              acc_btn_nxt  = acc_btn_r | cap_btn;
              acc_pr_nxt   = acc_pr_r | (cap_diff & cap_btn & edge_mask_r);
              acc_rl_nxt   = acc_rl_r | (cap_diff & prev_btn_r & edge_mask_r);
              sum_x_nxt    = sum_x_r + SUM_W'(cap_x);
              sum_y_nxt    = sum_y_r + SUM_W'(cap_y);
              count_nxt    = count_r + 1'b1;
              prev_btn_nxt = cap_btn;
              prev_x_nxt   = cap_x;
              prev_y_nxt   = cap_y;
            end
            // An armed tick starts the divider on the x sum.
            if (armed_r) begin
              dq_nxt    = sum_x_nxt[SUM_W-1] ? SUM_W'(-sum_x_nxt) : SUM_W'(sum_x_nxt);
              rem_nxt   = '0;
              step_nxt  = '0;
              axis_nxt  = 1'b0;
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, count_r}) : trial[CNT_W-1:0];
        dq_nxt   = quo;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          if (!axis_r) begin
            avg_x_nxt = quo_s;
            dq_nxt    = sum_y_r[SUM_W-1] ? SUM_W'(-sum_y_r) : SUM_W'(sum_y_r);
            rem_nxt   = '0;
            step_nxt  = '0;
            axis_nxt  = 1'b1;
          end else begin
            avg_y_nxt = quo_s;
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_ready) begin
          o_btn_nxt     = acc_btn_r;
          o_pr_nxt      = acc_pr_r;
          o_rl_nxt      = acc_rl_r;
          o_ax_nxt      = avg_x_r;
          o_ay_nxt      = avg_y_r;
          o_sx_nxt      = mx.sign;
          o_sy_nxt      = my.sign;
          o_dx_nxt      = dead_zone(avg_x_r, ign_stick_r);
          o_dy_nxt      = dead_zone(avg_y_r, ign_stick_r);
          out_valid_nxt = 1'b1;
          last_mx_nxt   = mx.last;
          hold_x_nxt    = mx.hold;
          last_my_nxt   = my.last;
          hold_y_nxt    = my.hold;
          acc_btn_nxt   = '0;
          acc_pr_nxt    = '0;
          acc_rl_nxt    = '0;
          sum_x_nxt     = '0;
          sum_y_nxt     = '0;
          count_nxt     = '0;
          armed_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer, configuration and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      no_ctrl_r   <= 1'b0;
      edge_mask_r <= EDGE_MASK_RST;
      rep_delay_r <= REPEAT_DELAY_RST;
      ign_stick_r <= 1'b0;
      prev_btn_r  <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      acc_btn_r   <= '0;
      acc_pr_r    <= '0;
      acc_rl_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      count_r     <= '0;
      armed_r     <= 1'b0;
      last_mx_r   <= '0;
      last_my_r   <= '0;
      hold_x_r    <= '0;
      hold_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      no_ctrl_r   <= no_ctrl_nxt;
      edge_mask_r <= edge_mask_nxt;
      rep_delay_r <= rep_delay_nxt;
      ign_stick_r <= ign_stick_nxt;
      prev_btn_r  <= prev_btn_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      acc_btn_r   <= acc_btn_nxt;
      acc_pr_r    <= acc_pr_nxt;
      acc_rl_r    <= acc_rl_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      count_r     <= count_nxt;
      armed_r     <= armed_nxt;
      last_mx_r   <= last_mx_nxt;
      last_my_r   <= last_my_nxt;
      hold_x_r    <= hold_x_nxt;
      hold_y_r    <= hold_y_nxt;
    end
  end

  // Divider and result payload registers.
  always_ff @(posedge clk) begin
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    axis_r  <= axis_nxt;
    avg_x_r <= avg_x_nxt;
    avg_y_r <= avg_y_nxt;
    o_btn_r <= o_btn_nxt;
    o_pr_r  <= o_pr_nxt;
    o_rl_r  <= o_rl_nxt;
    o_ax_r  <= o_ax_nxt;
    o_ay_r  <= o_ay_nxt;
    o_sx_r  <= o_sx_nxt;
    o_sy_r  <= o_sy_nxt;
    o_dx_r  <= o_dx_nxt;
    o_dy_r  <= o_dy_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_buttons  = o_btn_r;
  assign out_frame_presses  = o_pr_r;
  assign out_frame_releases = o_rl_r;
  assign out_avg_x          = o_ax_r;
  assign out_avg_y          = o_ay_r;
  assign out_menu_x_sign    = o_sx_r;
  assign out_menu_y_sign    = o_sy_r;
  assign out_dead_x         = o_dx_r;
  assign out_dead_y         = o_dy_r;

endmodule

[src/gfc_checker.sv]
// ============================================================================
// gfc_checker
// Port-level checks for the gamepad frame conditioner, bound to the core.
// ============================================================================
module gfc_checker
  import gfc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [15:0]       out_frame_buttons,
  input logic signed [1:0] out_menu_x_sign,
  input logic signed [1:0] out_menu_y_sign,
  input logic signed [7:0] out_dead_x,
  input logic signed [7:0] out_dead_y
);

  // An arm transaction leaves the input open on the following cycle.
  a_arm_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_ARM |=> in_ready)
    else $error("input not ready after an arm transaction");

  // A new result only appears while a computation holds the input closed.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a preceding computation");

  // Menu steps are -1, 0 or +1 only.
  a_menu_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_menu_x_sign != 2'sb10 && out_menu_y_sign != 2'sb10)
    else $error("menu step out of range");

  // Deadzoned sticks stay within the clamp.
  a_dead_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dead_x <= 8'sd70 && out_dead_x >= -8'sd70 &&
                  out_dead_y <= 8'sd70 && out_dead_y >= -8'sd70)
    else $error("deadzoned stick outside the clamp");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_buttons))
    else $error("stalled result changed");

endmodule

bind gamepad_frame_conditioner_core gfc_checker u_gfc_checker (.*);

[dv/gamepad_frame_conditioner_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// gamepad_frame_conditioner_core_tb
// Self-checking testbench for the gamepad frame conditioner. A scoreboard
// class keeps its own model of the frame state and predicts every frame
// result from the accepted input transactions. Random burst traffic and
// receiver stalls run under several register settings. The settings include
// a long held stick that wraps the hold timers and a long receiver hold-off.
// ============================================================================
module gamepad_frame_conditioner_core_tb;
  import gfc_pkg::*;

  localparam int DEPTH          = SNAP_DEPTH_DEF;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  // Stick values at the thresholds, deadzone and clamp edges and extremes.
  localparam int AXIS_CORNERS [15] = '{-36, -35, 35, 36, -8, -7, 7, 8, 0,
                                       -78, -79, 78, 79, -128, 127};

  typedef struct packed {
    logic              op;
    logic              new_data;
    logic [15:0]       buttons;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } pad_item_t;

  typedef struct packed {
    logic [15:0]       buttons;
    logic [15:0]       presses;
    logic [15:0]       releases;
    logic signed [7:0] avg_x;
    logic signed [7:0] avg_y;
    logic signed [1:0] menu_x;
    logic signed [1:0] menu_y;
    logic signed [7:0] dead_x;
    logic signed [7:0] dead_y;
  } frame_result_t;

  // Scoreboard: models the frame state and queues the predicted results.
  class frame_scoreboard;
    logic              no_ctrl;
    logic [15:0]       edge_mask;
    logic [6:0]        repeat_delay;
    logic              ignore_stick;
    logic [15:0]       prev_buttons;
    logic signed [7:0] prev_x, prev_y;
    logic [15:0]       acc_buttons, acc_presses, acc_releases;
    int                sum_x, sum_y, sample_count;
    bit                armed;
    int                last_menu_x, last_menu_y;
    logic [7:0]        hold_x, hold_y;
    frame_result_t     frames_due[$];
    int                errors;
    int                frames_checked;

    function new();
      no_ctrl = 1'b0;
      edge_mask = EDGE_MASK_RST;
      repeat_delay = REPEAT_DELAY_RST;
      ignore_stick = 1'b0;
      prev_buttons = '0;
      prev_x = '0;
      prev_y = '0;
      acc_buttons = '0;
      acc_presses = '0;
      acc_releases = '0;
      sum_x = 0;
      sum_y = 0;
      sample_count = 0;
      armed = 1'b0;
      last_menu_x = 0;
      last_menu_y = 0;
      hold_x = '0;
      hold_y = '0;
      errors = 0;
      frames_checked = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [15:0] data);
      case (idx)
        CFG_NO_CONTROLLER: no_ctrl = data[0];
        CFG_EDGE_MASK:     edge_mask = data;
        CFG_REPEAT_DELAY:  repeat_delay = data[6:0];
        CFG_IGNORE_STICK:  ignore_stick = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Deadzone: small values go to zero, others move toward zero and clamp.
    function int deadzoned(int s);
      if (ignore_stick) return 0;
      if (s < DEAD_BAND && s > -DEAD_BAND) return 0;
      if (s > 0) begin
        s -= DEAD_BAND;
        return (s > DEAD_LIMIT) ? DEAD_LIMIT : s;
      end
      s += DEAD_BAND;
      return (s < -DEAD_LIMIT) ? -DEAD_LIMIT : s;
    endfunction

    // Menu auto-repeat for one axis; the hold timer is 8 bits and wraps.
    function int menu_step(int v, inout int last, inout logic [7:0] hold);
      int dir;
      dir = 0;
      if (v < -MENU_THRESH && last >= -MENU_THRESH) begin
        dir = -1;
        hold = '0;
      end
      if (v > MENU_THRESH && last <= MENU_THRESH) begin
        dir = 1;
        hold = '0;
      end
      last = v;
      if (v < -MENU_THRESH || v > MENU_THRESH) hold = hold + 8'd1;
      else hold = '0;
      if (int'(repeat_delay) < int'($signed(hold))) begin
        last = 0;
        hold = '0;
      end
      return dir;
    endfunction

    // Updates the frame state for one accepted input transaction.
    function void record_item(pad_item_t it);
      logic [15:0]   btn, pr, rl;
      int            x, y, ax, ay;
      frame_result_t r;
      if (it.op == OP_ARM) begin
        armed = 1'b1;
        return;
      end
      // Capture while the frame buffer has room.
      if (sample_count < DEPTH) begin
        if (it.new_data) begin
          btn = it.buttons;
          x = it.stick_x;
          y = it.stick_y;
        end else begin
          btn = prev_buttons;
          x = prev_x;
          y = prev_y;
        end
        if (no_ctrl) btn = '0;
        pr = (btn ^ prev_buttons) & btn & edge_mask;
        rl = (btn ^ prev_buttons) & prev_buttons & edge_mask;
        acc_buttons |= btn;
        acc_presses |= pr;
        acc_releases |= rl;
        sum_x += x;
        sum_y += y;
        sample_count++;
        prev_buttons = btn;
        prev_x = 8'(x);
        prev_y = 8'(y);
      end
      if (!armed) return;
      // Armed tick: build the frame result and clear the frame.
      ax = (sample_count != 0) ? sum_x / sample_count : 0;
      ay = (sample_count != 0) ? sum_y / sample_count : 0;
      r.buttons = acc_buttons;
      r.presses = acc_presses;
      r.releases = acc_releases;
      r.avg_x = 8'(ax);
      r.avg_y = 8'(ay);
      r.menu_x = 2'(menu_step(ax, last_menu_x, hold_x));
      r.menu_y = 2'(menu_step(ay, last_menu_y, hold_y));
      r.dead_x = 8'(deadzoned(ax));
      r.dead_y = 8'(deadzoned(ay));
      frames_due.push_back(r);
      acc_buttons = '0;
      acc_presses = '0;
      acc_releases = '0;
      sum_x = 0;
      sum_y = 0;
      sample_count = 0;
      armed = 1'b0;
    endfunction

    function void compare_field(string name, logic signed [16:0] want,
                                logic signed [16:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Checks one result transaction against the oldest prediction.
    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (frames_due.size() == 0) begin
        $error("frame result with no prediction pending");
        errors++;
        return;
      end
      want = frames_due.pop_front();
      frames_checked++;
      compare_field("frame_buttons", want.buttons, got.buttons);
      compare_field("frame_presses", want.presses, got.presses);
      compare_field("frame_releases", want.releases, got.releases);
      compare_field("avg_x", want.avg_x, got.avg_x);
      compare_field("avg_y", want.avg_y, got.avg_y);
      compare_field("menu_x_sign", want.menu_x, got.menu_x);
      compare_field("menu_y_sign", want.menu_y, got.menu_y);
      compare_field("dead_x", want.dead_x, got.dead_x);
      compare_field("dead_y", want.dead_y, got.dead_y);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = 1'b0;
  logic              in_has_new_data = 1'b0;
  logic [15:0]       in_pad_buttons = '0;
  logic signed [7:0] in_pad_stick_x = '0;
  logic signed [7:0] in_pad_stick_y = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       out_frame_buttons;
  logic [15:0]       out_frame_presses;
  logic [15:0]       out_frame_releases;
  logic signed [7:0] out_avg_x;
  logic signed [7:0] out_avg_y;
  logic signed [1:0] out_menu_x_sign;
  logic signed [1:0] out_menu_y_sign;
  logic signed [7:0] out_dead_x;
  logic signed [7:0] out_dead_y;

  frame_scoreboard   sb;
  frame_result_t     seen;
  int                items_sent = 0;
  int                phases_run = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  int                rx_cycle = 0;
  int                rx_stall_left = 0;
  int                hold_left = 0;
  int                hold_off_requests = 0;
  int                hold_off_served = 0;
  logic [15:0]       gen_buttons = '0;
  logic signed [7:0] gen_x = '0;
  logic signed [7:0] gen_y = '0;

  gamepad_frame_conditioner_core #(
    .SNAP_DEPTH(DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_has_new_data   (in_has_new_data),
    .in_pad_buttons    (in_pad_buttons),
    .in_pad_stick_x    (in_pad_stick_x),
    .in_pad_stick_y    (in_pad_stick_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_buttons (out_frame_buttons),
    .out_frame_presses (out_frame_presses),
    .out_frame_releases(out_frame_releases),
    .out_avg_x         (out_avg_x),
    .out_avg_y         (out_avg_y),
    .out_menu_x_sign   (out_menu_x_sign),
    .out_menu_y_sign   (out_menu_y_sign),
    .out_dead_x        (out_dead_x),
    .out_dead_y        (out_dead_y)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: cycles through stall patterns and serves long hold-off requests.
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_off_served != hold_off_requests) begin
      hold_off_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= (rx_cycle[2:0] == 3'd0);
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.buttons = out_frame_buttons;
      seen.presses = out_frame_presses;
      seen.releases = out_frame_releases;
      seen.avg_x = out_avg_x;
      seen.avg_y = out_avg_y;
      seen.menu_x = out_menu_x_sign;
      seen.menu_y = out_menu_y_sign;
      seen.dead_x = out_dead_x;
      seen.dead_y = out_dead_y;
      sb.check_frame(seen);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one input transaction, with random gaps between bursts.
  task send_item(input pad_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_operation <= it.op;
    in_has_new_data <= it.new_data;
    in_pad_buttons <= it.buttons;
    in_pad_stick_x <= it.stick_x;
    in_pad_stick_y <= it.stick_y;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.record_item(it);
    items_sent++;
  endtask

  task send_fields(input logic op, input logic nd, input logic [15:0] btn,
                   input int x, input int y);
    pad_item_t it;
    it.op = op;
    it.new_data = nd;
    it.buttons = btn;
    it.stick_x = 8'(x);
    it.stick_y = 8'(y);
    send_item(it);
  endtask

  // Waits until every predicted result has arrived and the block is quiet.
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(input cfg_index_t idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task configure(input logic nc, input logic [15:0] mask, input logic [6:0] delay,
                 input logic ign);
    wait_idle();
    write_reg(CFG_NO_CONTROLLER, {15'd0, nc});
    write_reg(CFG_EDGE_MASK, mask);
    write_reg(CFG_REPEAT_DELAY, {9'd0, delay});
    write_reg(CFG_IGNORE_STICK, {15'd0, ign});
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // Stick values lean on holds, thresholds and edges, the rest random.
  function automatic logic signed [7:0] pick_axis(logic signed [7:0] last);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return last;
    if (r < 6) return 8'(AXIS_CORNERS[$urandom_range(0, 14)]);
    return 8'($urandom);
  endfunction

  function pad_item_t random_tick();
    pad_item_t it;
    case ($urandom_range(0, 5))
      0: gen_buttons = '0;
      1: gen_buttons = '1;
      2: ;
      3: gen_buttons = gen_buttons ^ (16'd1 << $urandom_range(0, 15));
      default: gen_buttons = 16'($urandom);
    endcase
    gen_x = pick_axis(gen_x);
    gen_y = pick_axis(gen_y);
    it.op = OP_TICK;
    it.new_data = ($urandom_range(0, 3) != 0);
    it.buttons = gen_buttons;
    it.stick_x = gen_x;
    it.stick_y = gen_y;
    return it;
  endfunction

  function pad_item_t arm_item();
    pad_item_t it;
    it = random_tick();
    it.op = OP_ARM;
    return it;
  endfunction

  // Mostly well-formed frames: a few ticks, an arm, then the emitting tick.
  task run_frames(input int quota);
    int        start;
    pad_item_t it;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 7) == 0) begin
        it = random_tick();
        if ($urandom_range(0, 1) != 0) it.op = OP_ARM;
        send_item(it);
      end else begin
        repeat ($urandom_range(0, 5)) send_item(random_tick());
        send_item(arm_item());
        if ($urandom_range(0, 5) == 0) send_item(arm_item());
        send_item(random_tick());
      end
    end
  endtask

  // One-sample frames with the stick held far over, long enough to wrap
  // the hold timers.
  task hold_stick_frames(input int frames);
    pad_item_t it;
    repeat (frames) begin
      send_item(arm_item());
      it = random_tick();
      it.new_data = 1'b1;
      it.stick_x = 8'($urandom_range(40, 127));
      it.stick_y = 8'(-int'($urandom_range(40, 128)));
      send_item(it);
    end
  endtask

  // Reset, directed transactions, then random phases under several settings.
  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First tick repeats the all-zero sample; arm twice stays armed.
    send_fields(OP_TICK, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_ARM, 1'b1, 16'hFFFF, -1, -1);
    send_fields(OP_TICK, 1'b1, 16'hFFFF, 127, -128);
    // Fill the buffer, then a tick that captures nothing.
    send_fields(OP_TICK, 1'b1, 16'h0000, -128, 127);
    send_fields(OP_TICK, 1'b0, 16'hFFFF, 127, 127);
    send_fields(OP_TICK, 1'b1, 16'h5A5A, 36, -36);
    send_fields(OP_TICK, 1'b1, 16'hA5A5, -35, 35);
    send_fields(OP_TICK, 1'b1, 16'hFFFF, 0, 0);
    // Armed tick with a full buffer still emits.
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_TICK, 1'b1, 16'h1234, 1, 1);
    // Deadzone and clamp edges, held over frames for menu repeat.
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_TICK, 1'b1, 16'h8001, 7, -7);
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_TICK, 1'b1, 16'h7FFE, 8, -8);
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_TICK, 1'b1, 16'h0000, 78, -78);
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_TICK, 1'b1, 16'hFFFF, 79, -79);
    send_fields(OP_ARM, 1'b0, 16'h0000, 0, 0);
    send_fields(OP_TICK, 1'b0, 16'h0000, 0, 0);

    configure(1'b0, 16'hFFFF, 7'd0, 1'b0);
    run_frames(90);
    configure(1'b1, 16'($urandom), 7'd127, 1'b1);
    run_frames(90);
    configure(1'b0, 16'h0000, 7'd3, 1'b0);
    run_frames(90);
    configure(1'b0, 16'hFFFF, 7'd127, 1'b0);
    hold_stick_frames(140);
    run_frames(30);
    // Long receiver hold-off while the sender keeps offering transactions.
    configure(1'($urandom_range(0, 1)), 16'($urandom), 7'($urandom_range(0, 10)),
              1'($urandom_range(0, 1)));
    hold_off_requests <= hold_off_requests + 1;
    run_frames(90);
    configure(1'b0, 16'hFFFF, 7'd5, 1'b0);
    run_frames(60);

    wait_idle();
    $display("Sent %0d input transactions over %0d register settings after the directed set.",
             items_sent, phases_run);
    $display("Checked %0d frame results, %0d mismatches.", sb.frames_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/gfc_pkg.sv
src/gamepad_frame_conditioner_core.sv
src/gfc_checker.sv
dv/gamepad_frame_conditioner_core_tb.sv
